// ----- hdl/cbs_pkg.sv -----
// Package for the complex bilinear splat block: sizes, opcodes and payload types.
// Used by every module in hdl/.
`default_nettype none
package cbs_pkg;

   // Canvas and stamp geometry. Canvas sides are powers of two.
   localparam int CW_BITS    = 8;
   localparam int CH_BITS    = 8;
   localparam int CANVAS_W   = 1 << CW_BITS;
   localparam int CANVAS_H   = 1 << CH_BITS;
   localparam int ADDR_BITS  = CW_BITS + CH_BITS;
   localparam int STAMP_W    = 256;
   localparam int STAMP_H    = 256;
   localparam int ACC_BITS   = 40;
   localparam int IO_BITS    = 40;
   localparam int POS_BITS   = 43;
   localparam int V_BITS     = 33;
   localparam int QDEPTH     = 4;
   localparam int QPTR_BITS  = 2;

   // Opcodes
   localparam logic [1:0] OP_SPLAT = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;

   // Register indexes
   localparam logic [2:0] REG_ORIGIN_X = 3'd0;
   localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
   localparam logic [2:0] REG_STEP_A_X = 3'd2;
   localparam logic [2:0] REG_STEP_A_Y = 3'd3;
   localparam logic [2:0] REG_STEP_B_X = 3'd4;
   localparam logic [2:0] REG_STEP_B_Y = 3'd5;
   localparam logic [2:0] REG_COEF_RE  = 3'd6;
   localparam logic [2:0] REG_COEF_IM  = 3'd7;

   typedef struct packed {
      logic [1:0]          opcode;
      logic [7:0]          sample_col;
      logic [7:0]          sample_row;
      logic signed [15:0]  sample_re;
      logic signed [15:0]  sample_im;
      logic [15:0]         cell_index;
      logic signed [39:0]  cell_re_in;
      logic signed [39:0]  cell_im_in;
   } req_type;

   typedef struct packed {
      logic signed [39:0]  cell_re_out;
      logic signed [39:0]  cell_im_out;
   } rsp_type;

   // Classified request passed from the front part to the back part.
   typedef struct packed {
      logic [1:0]                 opcode;
      logic                       drop;
      logic [CW_BITS-1:0]         jx;
      logic [CH_BITS-1:0]         jy;
      logic [15:0]                fx;
      logic [15:0]                fy;
      logic signed [V_BITS-1:0]   vr;
      logic signed [V_BITS-1:0]   vi;
      logic [16:0]                index;
      logic signed [39:0]         wre;
      logic signed [39:0]         wim;
   } cmd_type;

   // Queue status toward the front part.
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage
`default_nettype wire

// ----- hdl/cbs_queue.sv -----
// Short command queue between the front and back parts.
// Depends on cbs_pkg.
`default_nettype none
module cbs_queue (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     push,
   input  cbs_pkg::cmd_type        push_cmd,
   input  wire                     pop,
   output cbs_pkg::cmd_type        head,
   output cbs_pkg::qstat_type      stat
);
   import cbs_pkg::*;

   cmd_type               entry_ff [QDEPTH];
   logic [QPTR_BITS-1:0]  wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [QPTR_BITS:0]    count_ff, count_in;

   // Pointer and fill count update.
   always_comb begin
      wptr_in  = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff + {{QPTR_BITS{1'b0}}, push} - {{QPTR_BITS{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wptr_ff] <= push_cmd;
      end
   end

   assign head       = entry_ff[rptr_ff];
   assign stat.full  = (count_ff == QDEPTH[QPTR_BITS:0]);
   assign stat.empty = (count_ff == '0);

endmodule
`default_nettype wire

// ----- hdl/cbs_front.sv -----
// Front part: configuration registers, position and coefficient arithmetic.
// Depends on cbs_pkg; feeds cbs_queue.
`default_nettype none
module cbs_front (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     csr_we,
   input  wire  [2:0]              csr_index,
   input  wire  [31:0]             csr_wdata,
   input  wire                     take,
   input  cbs_pkg::req_type        req,
   input  cbs_pkg::qstat_type      qstat,
   output logic                    front_busy,
   output logic                    push,
   output cbs_pkg::cmd_type        push_cmd
);
   import cbs_pkg::*;

   logic signed [31:0] origin_x_ff, origin_y_ff, step_a_x_ff, step_a_y_ff;
   logic signed [31:0] step_b_x_ff, step_b_y_ff;
   logic signed [15:0] coef_re_ff, coef_im_ff;

   logic               s1_vld_ff, s2_vld_ff;
   req_type            s1_req_ff;
   logic signed [41:0] pax_ff, pbx_ff, pay_ff, pby_ff;
   logic signed [31:0] prr_ff, pii_ff, pri_ff, pir_ff;
   cmd_type            cmd_ff, cmd_in;
   logic signed [POS_BITS-1:0] x_pos, y_pos;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= 32'sd0;
         origin_y_ff <= 32'sd0;
         step_a_x_ff <= 32'sd65536;
         step_a_y_ff <= 32'sd0;
         step_b_x_ff <= 32'sd0;
         step_b_y_ff <= 32'sd65536;
         coef_re_ff  <= 16'sd4096;
         coef_im_ff  <= 16'sd0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ORIGIN_X: origin_x_ff <= csr_wdata;
            REG_ORIGIN_Y: origin_y_ff <= csr_wdata;
            REG_STEP_A_X: step_a_x_ff <= csr_wdata;
            REG_STEP_A_Y: step_a_y_ff <= csr_wdata;
            REG_STEP_B_X: step_b_x_ff <= csr_wdata;
            REG_STEP_B_Y: step_b_y_ff <= csr_wdata;
            REG_COEF_RE:  coef_re_ff  <= csr_wdata[15:0];
            REG_COEF_IM:  coef_im_ff  <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= take;
         s2_vld_ff <= s1_vld_ff;
      end
   end

   // Stage one: the products of position and coefficient.
   always_ff @(posedge clock) begin
      if (take) begin
         s1_req_ff <= req;
         pax_ff <= 42'(step_a_x_ff * $signed({1'b0, req.sample_col}));
         pbx_ff <= 42'(step_b_x_ff * $signed({1'b0, req.sample_row}));
         pay_ff <= 42'(step_a_y_ff * $signed({1'b0, req.sample_col}));
         pby_ff <= 42'(step_b_y_ff * $signed({1'b0, req.sample_row}));
         prr_ff <= req.sample_re * coef_re_ff;
         pii_ff <= req.sample_im * coef_im_ff;
         pri_ff <= req.sample_re * coef_im_ff;
         pir_ff <= req.sample_im * coef_re_ff;
      end
   end

   // Stage two: positions, floor split and complex value.
   always_comb begin
      x_pos = POS_BITS'(origin_x_ff) + POS_BITS'(pax_ff) + POS_BITS'(pbx_ff);
      y_pos = POS_BITS'(origin_y_ff) + POS_BITS'(pay_ff) + POS_BITS'(pby_ff);
      cmd_in.opcode = s1_req_ff.opcode;
      cmd_in.drop   = ({1'b0, s1_req_ff.sample_col} >= 9'(STAMP_W)) ||
                      ({1'b0, s1_req_ff.sample_row} >= 9'(STAMP_H));
      cmd_in.jx     = x_pos[16 +: CW_BITS];
      cmd_in.jy     = y_pos[16 +: CH_BITS];
      cmd_in.fx     = x_pos[15:0];
      cmd_in.fy     = y_pos[15:0];
      cmd_in.vr     = V_BITS'(prr_ff) - V_BITS'(pii_ff);
      cmd_in.vi     = V_BITS'(pri_ff) + V_BITS'(pir_ff);
      cmd_in.index  = {1'b0, s1_req_ff.cell_index};
      cmd_in.wre    = s1_req_ff.cell_re_in;
      cmd_in.wim    = s1_req_ff.cell_im_in;
   end

   always_ff @(posedge clock) begin
      if (s1_vld_ff) begin
         cmd_ff <= cmd_in;
      end
   end

   // Busy comes from registered state only, so take never loops back on itself.
   assign push       = s2_vld_ff;
   assign push_cmd   = cmd_ff;
   assign front_busy = s1_vld_ff | s2_vld_ff | qstat.full;

endmodule
`default_nettype wire

// ----- hdl/cbs_back.sv -----
// Back part: canvas memory, clearing pass and read-modify-write sequencer.
// Depends on cbs_pkg; drains cbs_queue.
`default_nettype none
module cbs_back (
   input  wire                     clock,
   input  wire                     reset,
   input  cbs_pkg::cmd_type        head,
   input  cbs_pkg::qstat_type      qstat,
   output logic                    pop,
   output logic                    clearing,
   output logic                    rsp_valid,
   output cbs_pkg::rsp_type        rsp_data
);
   import cbs_pkg::*;

   typedef enum logic [6:0] {
      B_CLEAR = 7'b0000001,
      B_IDLE  = 7'b0000010,
      B_RD    = 7'b0000100,
      B_MUL   = 7'b0001000,
      B_ACC   = 7'b0010000,
      B_WR    = 7'b0100000,
      B_RSP   = 7'b1000000
   } bstate_type;

   bstate_type state_ff, state_in;
   cmd_type    cur_ff;
   logic [ADDR_BITS-1:0]    clr_ff, clr_in;
   logic [1:0]              corner_ff, corner_in;
   logic [2*ACC_BITS-1:0]   mem [CANVAS_W*CANVAS_H];
   logic [2*ACC_BITS-1:0]   rd_ff, wdata;
   logic [ADDR_BITS-1:0]    addr;
   logic                    we;
   logic [32:0]             w_ff;
   logic [64:0]             pre_ff, pim_ff;
   logic                    nre_ff, nim_ff;
   logic [31:0]             mag_re, mag_im;
   logic [16:0]             wx, wy;
   logic [CW_BITS-1:0]      ax;
   logic [CH_BITS-1:0]      ay;
   logic [64:0]             rnd_re, rnd_im;
   logic signed [ACC_BITS:0] sum_re, sum_im;
   logic signed [ACC_BITS-1:0] new_re, new_im;
   logic signed [V_BITS:0]  sh_re, sh_im;

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      corner_in = corner_ff;
      pop       = 1'b0;
      unique case (state_ff)
         B_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) state_in = B_IDLE;
         end
         B_IDLE: begin
            corner_in = 2'd0;
            if (!qstat.empty) begin
               pop = 1'b1;
               unique case (head.opcode)
                  OP_SPLAT: state_in = head.drop ? B_IDLE : B_RD;
                  OP_WRITE: state_in = B_WR;
                  OP_READ:  state_in = B_RD;
                  default:  state_in = B_IDLE;
               endcase
            end
         end
         B_RD:  state_in = (cur_ff.opcode == OP_READ) ? B_RSP : B_MUL;
         B_MUL: state_in = B_ACC;
         B_ACC: begin
            corner_in = corner_ff + 1'b1;
            state_in  = (corner_ff == 2'd3) ? B_IDLE : B_RD;
         end
         B_WR:  state_in = B_IDLE;
         B_RSP: state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= B_CLEAR;
         clr_ff    <= '0;
         corner_ff <= 2'd0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         corner_ff <= corner_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) cur_ff <= head;
   end

   // Corner address and bilinear weight factors.
   always_comb begin
      ax = corner_ff[0] ? cur_ff.jx + 1'b1 : cur_ff.jx;
      ay = corner_ff[1] ? cur_ff.jy + 1'b1 : cur_ff.jy;
      wx = corner_ff[0] ? {1'b0, cur_ff.fx} : 17'h10000 - {1'b0, cur_ff.fx};
      wy = corner_ff[1] ? {1'b0, cur_ff.fy} : 17'h10000 - {1'b0, cur_ff.fy};
      mag_re = cur_ff.vr[V_BITS-1] ? 32'(-cur_ff.vr) : cur_ff.vr[31:0];
      mag_im = cur_ff.vi[V_BITS-1] ? 32'(-cur_ff.vi) : cur_ff.vi[31:0];
   end

   // Weight, then share magnitudes.
   always_ff @(posedge clock) begin
      if (state_ff == B_RD) w_ff <= 33'(wx * wy);
      if (state_ff == B_MUL) begin
         pre_ff <= mag_re * w_ff;
         pim_ff <= mag_im * w_ff;
         nre_ff <= cur_ff.vr[V_BITS-1];
         nim_ff <= cur_ff.vi[V_BITS-1];
      end
   end

   // Rounding half away from zero, then saturating accumulation.
   always_comb begin
      rnd_re = pre_ff + 65'h80000000;
      rnd_im = pim_ff + 65'h80000000;
      sh_re  = nre_ff ? -$signed({1'b0, rnd_re[64:32]}) : $signed({1'b0, rnd_re[64:32]});
      sh_im  = nim_ff ? -$signed({1'b0, rnd_im[64:32]}) : $signed({1'b0, rnd_im[64:32]});
      sum_re = $signed({rd_ff[2*ACC_BITS-1], rd_ff[2*ACC_BITS-1:ACC_BITS]})
               + (ACC_BITS+1)'(sh_re);
      sum_im = $signed({rd_ff[ACC_BITS-1], rd_ff[ACC_BITS-1:0]})
               + (ACC_BITS+1)'(sh_im);
      if (sum_re[ACC_BITS] != sum_re[ACC_BITS-1])
         new_re = {sum_re[ACC_BITS], {(ACC_BITS-1){~sum_re[ACC_BITS]}}};
      else
         new_re = sum_re[ACC_BITS-1:0];
      if (sum_im[ACC_BITS] != sum_im[ACC_BITS-1])
         new_im = {sum_im[ACC_BITS], {(ACC_BITS-1){~sum_im[ACC_BITS]}}};
      else
         new_im = sum_im[ACC_BITS-1:0];
   end

   // Memory port selection.
   always_comb begin
      we    = 1'b0;
      wdata = {new_re, new_im};
      addr  = (cur_ff.opcode == OP_SPLAT) ? {ay, ax} : cur_ff.index[ADDR_BITS-1:0];
      unique case (state_ff)
         B_CLEAR: begin
            we    = 1'b1;
            addr  = clr_ff;
            wdata = '0;
         end
         B_ACC: begin
            we   = 1'b1;
            addr = {ay, ax};
         end
         B_WR: begin
            we    = (cur_ff.index < 17'(CANVAS_W*CANVAS_H));
            wdata = {ACC_BITS'(cur_ff.wre), ACC_BITS'(cur_ff.wim)};
         end
         default: ;
      endcase
   end

   // Single-port canvas memory with registered read.
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rd_ff <= mem[addr];
   end

   assign clearing  = (state_ff == B_CLEAR);
   assign rsp_valid = (state_ff == B_RSP);
   always_comb begin
      if (cur_ff.index < 17'(CANVAS_W*CANVAS_H)) begin
         rsp_data.cell_re_out = IO_BITS'(rd_ff[2*ACC_BITS-1:ACC_BITS]);
         rsp_data.cell_im_out = IO_BITS'(rd_ff[ACC_BITS-1:0]);
      end else begin
         rsp_data = '0;
      end
   end

endmodule
`default_nettype wire

// ----- hdl/complex_bilinear_splat_2d.sv -----
// Top level of the complex bilinear splat block.
// Depends on cbs_pkg, cbs_front, cbs_queue and cbs_back.
`default_nettype none
// After reset the block clears its 65536-cell canvas, one cell per cycle, and
// holds busy high while it clears. A request is taken when start is high and
// busy is low; the front part registers the products, then the positions and
// the complex value, before the request enters a four-entry queue. The back
// part shares one single-port canvas memory: a splat is taken from the queue,
// then each of its four corners is read, multiplied, accumulated and written;
// a read is taken, then read, with its result on rsp_data for one cycle with
// rsp_valid; a write is taken and then written.
// The receiver cannot stall results. Configuration writes must come while idle.
module complex_bilinear_splat_2d (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     start,
   output logic                    busy,
   input  cbs_pkg::req_type        req_data,
   output logic                    rsp_valid,
   output cbs_pkg::rsp_type        rsp_data,
   input  wire                     csr_we,
   input  wire  [2:0]              csr_index,
   input  wire  [31:0]             csr_wdata
);
   import cbs_pkg::*;

   logic      take, front_busy, push, pop, clearing;
   cmd_type   push_cmd, head;
   qstat_type qstat;

   assign take = start & ~busy;
   assign busy = clearing | front_busy;

   cbs_front u_front (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .take(take), .req(req_data), .qstat(qstat),
      .front_busy(front_busy), .push(push), .push_cmd(push_cmd)
   );

   cbs_queue u_queue (
      .clock(clock), .reset(reset),
      .push(push), .push_cmd(push_cmd), .pop(pop),
      .head(head), .stat(qstat)
   );

   cbs_back u_back (
      .clock(clock), .reset(reset),
      .head(head), .qstat(qstat), .pop(pop), .clearing(clearing),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   // The clearing pass keeps requests out.
   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      clearing |-> busy) else $error("request port open during clearing");

   // A result is a single-cycle strobe.
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");

   // The queue is never pushed while full.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!qstat.full || pop)) else $error("queue overflow");

   // A taken request keeps the front part busy in the next cycle.
   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      take |=> busy) else $error("front part free right after a request");

endmodule
`default_nettype wire
